/* rtl/tccu_pkg.sv */
// Shared types, constants and helpers for the compass heading unit.
`timescale 1ns / 1ps
package tccu_pkg;

  typedef enum logic [2:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Y    = 3'd1,
    CFG_OFFSET_Z    = 3'd2,
    CFG_GAIN_Y      = 3'd3,
    CFG_GAIN_Z      = 3'd4,
    CFG_DECLINATION = 3'd5
  } cfg_idx_e;

  localparam int TAB_LEN = 24;
  localparam int AW      = 34;
  localparam int CW      = 33;

  localparam logic signed [CW-1:0] KQ30         = 33'sd652032874;
  localparam logic signed [AW-1:0] HALF_TURN    = 34'sd2147483648;
  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sd1073741824;

  typedef struct packed {
    logic signed [AW-1:0] z;
    logic                 flip;
  } ang_t;

  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41721;
      5'd15:   r = 30'd20860;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2607;
      5'd19:   r = 30'd1303;
      5'd20:   r = 30'd651;
      5'd21:   r = 30'd325;
      5'd22:   r = 30'd162;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [95:0] v);
    logic signed [23:0] r;
    if (v > 96'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -96'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tccu_pipe.sv */
// Enabled delay line for payload that rides alongside the CORDIC stages.
`timescale 1ns / 1ps
module tccu_pipe #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

/* rtl/tccu_angle.sv */
// Hundredths of a degree to folded binary angle, four stages.
`timescale 1ns / 1ps
module tccu_angle (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] h_i,
  output tccu_pkg::ang_t     ang_o
);

  localparam logic [50:0] MREC = 51'd61083979;

  logic [16:0] m_d;
  logic        neg1_q, neg2_q, neg3_q;
  logic [31:0] base1_q, base2_q, base3_q;
  logic [24:0] t1_q, t2_q;
  logic [14:0] q0_q, q3_q;
  logic [25:0] rem_c;
  logic [31:0] a_c, sa_c;
  logic signed [tccu_pkg::AW-1:0] s_c;
  tccu_pkg::ang_t ang_d, ang_q;

  assign m_d = h_i[15] ? (17'd0 - 17'(h_i)) : 17'(h_i);
  assign rem_c = 26'(t2_q) - 26'(q0_q) * 26'd1125;

  always_comb begin
    a_c  = base3_q + 32'(q3_q);
    sa_c = neg3_q ? (32'd0 - a_c) : a_c;
    s_c  = tccu_pkg::AW'($signed(sa_c));
    unique if (s_c > tccu_pkg::QUARTER_TURN) begin
      ang_d.z    = s_c - tccu_pkg::HALF_TURN;
      ang_d.flip = 1'b1;
    end else if (s_c < -tccu_pkg::QUARTER_TURN) begin
      ang_d.z    = s_c + tccu_pkg::HALF_TURN;
      ang_d.flip = 1'b1;
    end else begin
      ang_d.z    = s_c;
      ang_d.flip = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= h_i[15];
      base1_q <= 32'(m_d * 32'd119304);
      t1_q    <= 25'((30'(m_d) * 30'd23296 + 30'd18000) >> 5);
      neg2_q  <= neg1_q;
      base2_q <= base1_q;
      t2_q    <= t1_q;
      q0_q    <= 15'((51'(t1_q) * MREC) >> 36);
      neg3_q  <= neg2_q;
      base3_q <= base2_q;
      q3_q    <= q0_q + 15'(rem_c >= 26'd1125);
      ang_q   <= ang_d;
    end
  end

  assign ang_o = ang_q;

`ifndef NO_ASSERTIONS
  a_fold_range: assert property (@(posedge clk_i)
    !$isunknown(ang_q) |->
      ((ang_q.z <= tccu_pkg::QUARTER_TURN) && (ang_q.z >= -tccu_pkg::QUARTER_TURN)))
    else $error("folded angle out of quarter-turn range");
`endif

endmodule

/* rtl/tccu_rot.sv */
// Rotation-mode CORDIC: cosine and sine in Q30, one iteration per stage.
`timescale 1ns / 1ps
module tccu_rot #(
  parameter int N = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  tccu_pkg::ang_t                      ang_i,
  output logic signed [tccu_pkg::CW-1:0]      cos_o,
  output logic signed [tccu_pkg::CW-1:0]      sin_o
);

  localparam int CW = tccu_pkg::CW;
  localparam int AW = tccu_pkg::AW;

  logic signed [CW-1:0] x_q [N];
  logic signed [CW-1:0] y_q [N];
  logic signed [AW-1:0] z_q [N];
  logic                 f_q [N];
  logic signed [CW-1:0] cos_q, sin_q;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, dx, dy;
    logic signed [AW-1:0] zi, at;
    logic                 fi;
    if (i == 0) begin : g_first
      assign xi = tccu_pkg::KQ30;
      assign yi = '0;
      assign zi = ang_i.z;
      assign fi = ang_i.flip;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign fi = f_q[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = AW'(tccu_pkg::atan_val(5'(i)));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i] <= fi;
        if (zi >= 0) begin
          x_q[i] <= xi - dx;
          y_q[i] <= yi + dy;
          z_q[i] <= zi - at;
        end else begin
          x_q[i] <= xi + dx;
          y_q[i] <= yi - dy;
          z_q[i] <= zi + at;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_q <= f_q[N-1] ? -x_q[N-1] : x_q[N-1];
      sin_q <= f_q[N-1] ? -y_q[N-1] : y_q[N-1];
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

/* rtl/tccu_vec.sv */
// Vectoring-mode CORDIC: binary angle of atan2(sn, cs), one iteration per stage.
`timescale 1ns / 1ps
module tccu_vec #(
  parameter int N = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [23:0] sn_i,
  input  logic signed [23:0] cs_i,
  output logic [31:0]        a_o
);

  localparam int VW = 58;
  localparam int AW = tccu_pkg::AW;

  logic signed [VW-1:0] x0_c, y0_c, x0_q, y0_q;
  logic signed [AW-1:0] z0_q;
  logic signed [VW-1:0] x_q [N];
  logic signed [VW-1:0] y_q [N];
  logic signed [AW-1:0] z_q [N];

  assign x0_c = VW'($signed({cs_i, 32'd0}));
  assign y0_c = VW'($signed({sn_i, 32'd0}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (cs_i < 0) begin
        x0_q <= -x0_c;
        y0_q <= -y0_c;
        z0_q <= tccu_pkg::HALF_TURN;
      end else begin
        x0_q <= x0_c;
        y0_q <= y0_c;
        z0_q <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [VW-1:0] xi, yi, dx, dy;
    logic signed [AW-1:0] zi, at;
    if (i == 0) begin : g_first
      assign xi = x0_q;
      assign yi = y0_q;
      assign zi = z0_q;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = AW'(tccu_pkg::atan_val(5'(i)));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yi < 0) begin
          x_q[i] <= xi - dx;
          y_q[i] <= yi + dy;
          z_q[i] <= zi - at;
        end else begin
          x_q[i] <= xi + dx;
          y_q[i] <= yi - dy;
          z_q[i] <= zi + at;
        end
      end
    end
  end

  assign a_o = z_q[N-1][31:0];

endmodule

/* rtl/tilt_compensated_compass_heading_unit.sv */
// Throughput: one beat per cycle unless an output stall freezes the pipeline;
// each CORDIC iteration is its own stage.
// Output stall freezes the whole pipeline while a result waits; nothing is lost.
// Reset clears all valid bits and loads the registers with their defaults
// (offsets 0, gains 4096, declination 0).
`timescale 1ns / 1ps
module tilt_compensated_compass_heading_unit #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [12:0] word_y_i,
  input  logic signed [12:0] word_z_i,
  input  logic signed [12:0] word_x_i,
  input  logic               tilt_enable_i,
  input  logic signed [15:0] roll_angle_i,
  input  logic signed [15:0] pitch_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        heading_o,
  output logic signed [23:0] level_x_o,
  output logic signed [23:0] level_y_o
);

  localparam int N  = CORDIC_STEPS;
  localparam int XW = (((14 + FRAC_BITS) > 17) ? (14 + FRAC_BITS) : 17) + 1;
  localparam int YW = XW + 5;
  localparam int CW = tccu_pkg::CW;
  localparam int RW = 34;
  localparam int LT = 13 + 2 * N;
  localparam int DW = 1 + XW + 2 * YW;
  localparam logic signed [95:0] HALF30 = 96'sd536870912;

  logic               en;
  logic [LT-1:0]      vld_q;

  logic signed [16:0] off_x_q, off_y_q, off_z_q;
  logic [15:0]        gain_y_q, gain_z_q;
  logic signed [15:0] decl_q;

  // stage 0: input beat
  logic signed [12:0] wy0_q, wz0_q, wx0_q;
  logic               tilt0_q;
  logic signed [15:0] roll0_q, pitch0_q;

  // stages 1 and 2: offsets and soft-iron scale
  logic signed [XW-1:0]    x1_q, yp1_q, zp1_q, x2_q;
  logic                    tilt1_q, tilt2_q;
  logic signed [XW+16:0]   py_c, pz_c;
  logic signed [YW-1:0]    y2_q, z2_q;

  // aligned with the rotation outputs
  logic [DW-1:0]           dly_d, dly_q;
  logic signed [XW-1:0]    x6;
  logic signed [YW-1:0]    y6, z6;
  logic                    tilt6;
  tccu_pkg::ang_t          ang_r, ang_p;
  logic signed [CW-1:0]    cr, sr, cp, sp;

  // tilt products
  logic signed [2*CW-1:0]  psrsp_q, pcrsp_q;
  logic signed [YW+CW-1:0] pycr_q, pzsr_q;
  logic signed [XW-1:0]    x7_q, x8_q, x9_q;
  logic signed [YW-1:0]    y7_q, z7_q, y8_q, z8_q;
  logic signed [CW-1:0]    cp7_q, cp8_q;
  logic                    tilt7_q, tilt8_q, tilt9_q;
  logic signed [RW-1:0]    rsp_q, rcp_q;
  logic signed [23:0]      ly8_q, ly9_q, lx10_q, ly10_q;
  logic signed [XW+CW-1:0] pxcp_q;
  logic signed [YW+RW-1:0] pyr_q, pzr_q;
  logic signed [95:0]      lys_c, lxs_c;

  // heading
  logic [31:0]        ang_a;
  logic [47:0]        lvl_d, lvl_q;
  logic signed [23:0] lx11, ly11, lx12_q, ly12_q;
  logic [15:0]        hd12_q;
  logic [63:0]        hm_c;
  logic signed [17:0] hv_c, hr_c;

  logic [15:0]        heading_q;
  logic signed [23:0] level_x_q, level_y_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign out_valid_o = vld_q[LT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      off_x_q  <= '0;
      off_y_q  <= '0;
      off_z_q  <= '0;
      gain_y_q <= 16'd4096;
      gain_z_q <= 16'd4096;
      decl_q   <= '0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[LT-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tccu_pkg::CFG_OFFSET_X:    off_x_q  <= $signed(cfg_data_i);
          tccu_pkg::CFG_OFFSET_Y:    off_y_q  <= $signed(cfg_data_i);
          tccu_pkg::CFG_OFFSET_Z:    off_z_q  <= $signed(cfg_data_i);
          tccu_pkg::CFG_GAIN_Y:      gain_y_q <= cfg_data_i[15:0];
          tccu_pkg::CFG_GAIN_Z:      gain_z_q <= cfg_data_i[15:0];
          tccu_pkg::CFG_DECLINATION: decl_q   <= $signed(cfg_data_i[15:0]);
          default: ;
        endcase
      end
    end
  end

  assign py_c = yp1_q * $signed({1'b0, gain_y_q});
  assign pz_c = zp1_q * $signed({1'b0, gain_z_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      wy0_q    <= word_y_i;
      wz0_q    <= word_z_i;
      wx0_q    <= word_x_i;
      tilt0_q  <= tilt_enable_i;
      roll0_q  <= roll_angle_i;
      pitch0_q <= pitch_angle_i;

      x1_q    <= XW'(off_x_q) - (XW'(wx0_q) <<< FRAC_BITS);
      yp1_q   <= XW'(off_y_q) - (XW'(wy0_q) <<< FRAC_BITS);
      zp1_q   <= XW'(off_z_q) + (XW'(wz0_q) <<< FRAC_BITS);
      tilt1_q <= tilt0_q;

      x2_q    <= x1_q;
      y2_q    <= YW'((py_c + (XW+17)'(2048)) >>> 12);
      z2_q    <= YW'((pz_c + (XW+17)'(2048)) >>> 12);
      tilt2_q <= tilt1_q;
    end
  end

  assign dly_d = {tilt2_q, x2_q, y2_q, z2_q};

  tccu_pipe #(.W(DW), .N(3 + N)) u_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (dly_d),
    .q_o   (dly_q)
  );

  assign tilt6 = dly_q[DW-1];
  assign x6    = $signed(dly_q[DW-2 -: XW]);
  assign y6    = $signed(dly_q[2*YW-1 -: YW]);
  assign z6    = $signed(dly_q[YW-1:0]);

  tccu_angle u_ang_r (.clk_i(clk_i), .en_i(en), .h_i(roll0_q),  .ang_o(ang_r));
  tccu_angle u_ang_p (.clk_i(clk_i), .en_i(en), .h_i(pitch0_q), .ang_o(ang_p));

  tccu_rot #(.N(N)) u_rot_r (
    .clk_i(clk_i), .en_i(en), .ang_i(ang_r), .cos_o(cr), .sin_o(sr)
  );
  tccu_rot #(.N(N)) u_rot_p (
    .clk_i(clk_i), .en_i(en), .ang_i(ang_p), .cos_o(cp), .sin_o(sp)
  );

  always_comb begin
    lys_c = (96'(pycr_q) + 96'(pzsr_q) + HALF30) >>> 30;
    lxs_c = (96'(pxcp_q) - 96'(pyr_q) + 96'(pzr_q) + HALF30) >>> 30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      psrsp_q <= sr * sp;
      pcrsp_q <= cr * sp;
      pycr_q  <= y6 * cr;
      pzsr_q  <= z6 * sr;
      x7_q    <= x6;
      y7_q    <= y6;
      z7_q    <= z6;
      cp7_q   <= cp;
      tilt7_q <= tilt6;

      rsp_q   <= RW'((96'(psrsp_q) + HALF30) >>> 30);
      rcp_q   <= RW'((96'(pcrsp_q) + HALF30) >>> 30);
      ly8_q   <= tilt7_q ? tccu_pkg::sat24(lys_c) : tccu_pkg::sat24(96'(y7_q));
      x8_q    <= x7_q;
      y8_q    <= y7_q;
      z8_q    <= z7_q;
      cp8_q   <= cp7_q;
      tilt8_q <= tilt7_q;

      pxcp_q  <= x8_q * cp8_q;
      pyr_q   <= y8_q * rsp_q;
      pzr_q   <= z8_q * rcp_q;
      x9_q    <= x8_q;
      ly9_q   <= ly8_q;
      tilt9_q <= tilt8_q;

      lx10_q  <= tilt9_q ? tccu_pkg::sat24(lxs_c) : tccu_pkg::sat24(96'(x9_q));
      ly10_q  <= ly9_q;
    end
  end

  tccu_vec #(.N(N)) u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .sn_i  (lx10_q),
    .cs_i  (ly10_q),
    .a_o   (ang_a)
  );

  assign lvl_d = {lx10_q, ly10_q};

  tccu_pipe #(.W(48), .N(1 + N)) u_lvl (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (lvl_d),
    .q_o   (lvl_q)
  );

  assign lx11 = $signed(lvl_q[47:24]);
  assign ly11 = $signed(lvl_q[23:0]);
  assign hm_c = 64'(ang_a) * 64'd36000 + 64'd2147483648;
  assign hv_c = $signed({2'b00, hd12_q}) + 18'sd18000 + 18'(decl_q);

  always_comb begin
    priority if (hv_c < 0) begin
      hr_c = hv_c + 18'sd36000;
    end else if (hv_c >= 18'sd72000) begin
      hr_c = hv_c - 18'sd72000;
    end else if (hv_c >= 18'sd36000) begin
      hr_c = hv_c - 18'sd36000;
    end else begin
      hr_c = hv_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hd12_q    <= hm_c[47:32];
      lx12_q    <= lx11;
      ly12_q    <= ly11;
      heading_q <= hr_c[15:0];
      level_x_q <= lx12_q;
      level_y_q <= ly12_q;
    end
  end

  assign heading_o = heading_q;
  assign level_x_o = level_x_q;
  assign level_y_o = level_y_q;

`ifndef NO_ASSERTIONS
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o < 16'd36000))
    else $error("heading not reduced");
  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> (vld_q[LT-1] == $past(vld_q[LT-2])))
    else $error("valid bit lost in pipeline");
`endif

endmodule

/* verif/tb_tilt_compensated_compass_heading_unit.sv */
// Self-checking testbench for the tilt-compensated compass heading unit.
`timescale 1ns / 1ps
module tb_tilt_compensated_compass_heading_unit;

  localparam int STEPS = 16;
  localparam int FRAC = 4;
  localparam int LATENCY = 13 + 2 * STEPS;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0]        heading;
    logic signed [23:0] lx;
    logic signed [23:0] ly;
  } heading_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [16:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [12:0] word_y_i = '0;
  logic signed [12:0] word_z_i = '0;
  logic signed [12:0] word_x_i = '0;
  logic               tilt_enable_i = 1'b0;
  logic signed [15:0] roll_angle_i = '0;
  logic signed [15:0] pitch_angle_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [15:0]        heading_o;
  logic signed [23:0] level_x_o;
  logic signed [23:0] level_y_o;

  tilt_compensated_compass_heading_unit #(.CORDIC_STEPS(STEPS), .FRAC_BITS(FRAC)) i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  longint    cycles = 0;
  int        errors = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  heading_t  expected_q[$];

  longint    off_x = 0, off_y = 0, off_z = 0, gain_y = 4096, gain_z = 4096, decl = 0;

  longint    atan_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81};

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (s == 0) ? v : ((v + (64'sd1 <<< (s - 1))) >>> s);
  endfunction

  function automatic longint clip24(longint v);
    return v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v);
  endfunction

  task automatic trig(input longint h, output longint c, output longint s);
    longint m, a, x, y, z, dx, dy;
    bit     flip;
    m = h < 0 ? -h : h;
    a = (m * 64'sd4294967296 + 18000) / 36000;
    if (h < 0) a = -a;
    a = longint'(a[31:0]);
    if (a >= 64'sd2147483648) a -= 64'sd4294967296;
    flip = 0;
    if (a > 64'sd1073741824) begin
      a -= 64'sd2147483648; flip = 1;
    end else if (a < -64'sd1073741824) begin
      a += 64'sd2147483648; flip = 1;
    end
    x = 652032874; y = 0; z = a;
    for (int i = 0; i < STEPS; i++) begin
      dx = shr(y, i); dy = shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint bearing(longint sn, longint cs);
    longint x, y, z, dx, dy;
    x = cs * 64'sd4294967296; y = sn * 64'sd4294967296; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd2147483648;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = shr(y, i); dy = shr(x, i);
      if (y < 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    return longint'({32'd0, z[31:0]});
  endfunction

  task automatic predict_heading(input logic signed [12:0] wy, wz, wx, input logic te,
                                 input logic signed [15:0] roll, pitch);
    longint   x, y, z, lx, ly, cr, sr, cp, sp, a, hd;
    heading_t r;
    x = -longint'(wx) * (1 << FRAC) + off_x;
    y = round_shr((-longint'(wy) * (1 << FRAC) + off_y) * gain_y, 12);
    z = round_shr((longint'(wz) * (1 << FRAC) + off_z) * gain_z, 12);
    lx = x; ly = y;
    if (te) begin
      trig(roll, cr, sr);
      trig(pitch, cp, sp);
      lx = round_shr(x * cp - y * round_shr(sr * sp, 30) + z * round_shr(cr * sp, 30), 30);
      ly = round_shr(y * cr + z * sr, 30);
    end
    lx = clip24(lx); ly = clip24(ly);
    a = bearing(lx, ly);
    hd = (a * 36000 + 64'sd2147483648) >>> 32;
    hd = (hd + 18000 + decl) % 36000;
    if (hd < 0) hd += 36000;
    r.heading = hd[15:0]; r.lx = lx[23:0]; r.ly = ly[23:0];
    expected_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    heading_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          e = expected_q.pop_front();
          if (heading_o !== e.heading) report_mismatch("heading", heading_o, e.heading);
          if (level_x_o !== e.lx) report_mismatch("level_x", level_x_o, e.lx);
          if (level_y_o !== e.ly) report_mismatch("level_y", level_y_o, e.ly);
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_sample(input logic signed [12:0] wy, wz, wx, input logic te,
                             input logic signed [15:0] roll, pitch);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_y_i <= wy; word_z_i <= wz; word_x_i <= wx;
    tilt_enable_i <= te; roll_angle_i <= roll; pitch_angle_i <= pitch;
    predict_heading(wy, wz, wx, te, roll, pitch);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input tccu_pkg::cfg_idx_e idx, input longint v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v[16:0];
    @(posedge clk_i);
    case (idx)
      tccu_pkg::CFG_OFFSET_X:    off_x = longint'($signed(v[16:0]));
      tccu_pkg::CFG_OFFSET_Y:    off_y = longint'($signed(v[16:0]));
      tccu_pkg::CFG_OFFSET_Z:    off_z = longint'($signed(v[16:0]));
      tccu_pkg::CFG_GAIN_Y:      gain_y = longint'(v[15:0]);
      tccu_pkg::CFG_GAIN_Z:      gain_z = longint'(v[15:0]);
      tccu_pkg::CFG_DECLINATION: decl = longint'($signed(v[15:0]));
      default: ;
    endcase
  endtask

  task automatic set_calibration(input longint ox, oy, oz, gy, gz, dc);
    drain();
    write_reg(tccu_pkg::CFG_OFFSET_X, ox);
    write_reg(tccu_pkg::CFG_OFFSET_Y, oy);
    write_reg(tccu_pkg::CFG_OFFSET_Z, oz);
    write_reg(tccu_pkg::CFG_GAIN_Y, gy);
    write_reg(tccu_pkg::CFG_GAIN_Z, gz);
    write_reg(tccu_pkg::CFG_DECLINATION, dc);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_angle();
    return 16'($signed($urandom_range(36000)) - 18000);
  endfunction

  task automatic test_directed;
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(0, 0, 0, 1, 0, 0);
    send_sample(13'sh0fff, 13'sh0fff, 13'sh0fff, 0, 0, 0);
    send_sample(-13'sd4096, -13'sd4096, -13'sd4096, 0, 0, 0);
    send_sample(-13'sd4096, 13'sh0fff, -13'sd4096, 1, 18000, -18000);
    send_sample(100, -200, 300, 1, 9000, 4500);
    send_sample(-500, 50, 0, 1, -9000, -9000);
    send_sample(0, 0, 1000, 1, -18000, 18000);
    send_sample(1000, 0, 0, 1, 16'sh7fff, 16'sh8000);
    send_sample(1000, 0, 0, 0, 16'sh7fff, 16'sh8000);
    send_sample(-4096, -4096, 4095, 1, 4500, 13500);
    set_calibration(65535, 65535, 65535, 65535, 65535, 18000);
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(-4096, 4095, -4096, 1, 3000, 6000);
    send_sample(13'sh0fff, -4096, 13'sh0fff, 1, -12000, 17000);
    set_calibration(-65536, -65536, -65536, 0, 0, -18000);
    send_sample(0, 0, 0, 0, 0, 0);
    send_sample(4095, 4095, 4095, 1, 9000, 9000);
    send_sample(-4096, -4096, -4096, 1, -4500, 0);
    set_calibration(0, 0, 0, 4096, 4096, 0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        set_calibration($signed($urandom_range(131071)) - 65536,
                        $signed($urandom_range(131071)) - 65536,
                        $signed($urandom_range(131071)) - 65536,
                        $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(3000, 6000),
                        $urandom_range(3) == 0 ? $urandom_range(65535) : $urandom_range(3000, 6000),
                        $signed($urandom_range(36000)) - 18000);
      end
      send_sample(13'($urandom), 13'($urandom), 13'($urandom), $urandom_range(3) != 0,
                  $urandom_range(9) == 0 ? 16'($urandom) : rand_angle(),
                  $urandom_range(9) == 0 ? 16'($urandom) : rand_angle());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 11; recv_idle = 48;
    test_directed();
    test_random(600);
    send_idle = 48; recv_idle = 11;
    test_random(600);
    send_idle = 0; recv_idle = 0;
    test_random(650);
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
